// ----- rtl/core/spu_pkg.sv -----
`default_nettype none
package spu_pkg;

    localparam int COUNT_BITS   = 24;
    localparam int CORDIC_STEPS = 16;

    localparam int IN_W      = 20;
    localparam int SUM_W     = IN_W + COUNT_BITS;
    localparam int DIFF_W    = IN_W + 1;
    localparam int MAG_W     = IN_W;
    localparam int SQ_W      = 2 * MAG_W;
    localparam int RHO2_W    = SQ_W + 1;
    localparam int R2_W      = SQ_W + 2;
    localparam int RHO_EXTRA = 10;

    // Square root operand must have an even number of bits.
    localparam int SQRT_IN_W = RHO2_W + 2 * RHO_EXTRA + 1;
    localparam int ROOT_W    = SQRT_IN_W / 2;
    localparam int REM_W     = ROOT_W + 2;
    localparam int SQRT_CNT_W = $clog2(ROOT_W);

    localparam int OUT_XY_W = 22;
    localparam int OUT_Z_W  = 21;
    localparam int RAD_W    = 22;
    localparam int F_W      = RAD_W + 1;
    localparam int ANG_W    = 25;

    localparam int DIV_N_W   = 56;
    localparam int DIV_D_W   = 32;
    localparam int DIV_CNT_W = $clog2(DIV_N_W);

    localparam int MUL_W  = 25;
    localparam int PROD_W = 2 * MUL_W;

    localparam int X_W       = 35;
    localparam int Z_W       = 26;
    localparam int CSTEP_W   = $clog2(CORDIC_STEPS);
    localparam int TAB_N     = 24;
    localparam int TAB_IDX_W = 5;
    localparam int TAB_W     = 23;

    localparam logic [ANG_W-1:0] ANG_HALF_TURN    = ANG_W'(1) << (ANG_W - 1);
    localparam logic [ANG_W-1:0] ANG_QUARTER_TURN = ANG_W'(1) << (ANG_W - 2);

    // Arctangent of 2^-i as a fraction of a half turn, 2^24 to the half turn.
    localparam logic [TAB_W-1:0] ATAN_TAB [TAB_N] = '{
        23'd4194304, 23'd2476042, 23'd1308273, 23'd664100, 23'd333339, 23'd166832,
        23'd83436, 23'd41721, 23'd20861, 23'd10430, 23'd5215, 23'd2608,
        23'd1304, 23'd652, 23'd326, 23'd163, 23'd81, 23'd41,
        23'd20, 23'd10, 23'd5, 23'd3, 23'd1, 23'd1
    };

    typedef enum logic [1:0] {
        REQ_ACCUMULATE = 2'd0,
        REQ_MEASURE    = 2'd1,
        REQ_TRANSFORM  = 2'd2,
        REQ_CLEAR      = 2'd3
    } req_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CDIV,
        ST_CWAIT,
        ST_DIFF,
        ST_SQ_X,
        ST_SQ_Y,
        ST_SQ_Z,
        ST_SQ_SUM,
        ST_R_WAIT,
        ST_RHO_START,
        ST_RHO_WAIT,
        ST_CORD_START,
        ST_CORD_WAIT,
        ST_F_MUL,
        ST_F_RND,
        ST_MX_MUL,
        ST_MX_DIV,
        ST_MX_WAIT,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage
`default_nettype wire

// ----- rtl/core/spu_cmd_if.sv -----
`default_nettype none
interface spu_cmd_if;
    logic                            valid;
    logic                            ready;
    logic [1:0]                      req_type;
    logic signed [spu_pkg::IN_W-1:0] point_x;
    logic signed [spu_pkg::IN_W-1:0] point_y;
    logic signed [spu_pkg::IN_W-1:0] point_z;
    logic                            fiber_end;

    modport source (output valid, req_type, point_x, point_y, point_z, fiber_end,
                    input ready);
    modport sink (input valid, req_type, point_x, point_y, point_z, fiber_end,
                  output ready);
endinterface
`default_nettype wire

// ----- rtl/core/spu_res_if.sv -----
`default_nettype none
interface spu_res_if;
    logic                                valid;
    logic                                ready;
    logic signed [spu_pkg::OUT_XY_W-1:0] new_x;
    logic signed [spu_pkg::OUT_XY_W-1:0] new_y;
    logic [spu_pkg::OUT_Z_W-1:0]         new_z;
    logic                                fiber_end_out;
    logic                                status;

    modport source (output valid, new_x, new_y, new_z, fiber_end_out, status,
                    input ready);
    modport sink (input valid, new_x, new_y, new_z, fiber_end_out, status,
                  output ready);
endinterface
`default_nettype wire

// ----- rtl/core/spherical_point_unfold.sv -----
// Spherical point unfolding.
// Input items arrive on cmd and results leave on res, both valid/ready channels.
// An item moves when valid and ready are high at the same rising edge of clk.
// Software streams its point set three times: accumulate (sums and count),
// measure (fixes the barycentre on the first such item, then tracks the largest
// distance) and transform (maps the point to an unfolded position). A clear item
// returns all state to zero. Accumulate and clear give no result.
// The block works on one item at a time and cmd.ready is low until it is done.
// A measure result passes through the 31-step square root unit; a transform result
// also uses the shared 56-step restoring divider (two quotients per transform)
// and the 16-step CORDIC. The first measure or transform after accumulation also
// runs three divisions for the barycentre. With no points accumulated the result
// is valid in the cycle after the item is accepted. The next item is accepted
// only once the result has been taken and the block is back in its idle state.
// The result is held in an output register until res.ready takes it; a stalled
// receiver just holds the block in that state.
// rst_n is asynchronous and active low; after it all sums, the count, the centre
// and the largest radius are zero and the block is ready.
`default_nettype none
module spherical_point_unfold (
    input  wire logic       clk,
    input  wire logic       rst_n,
    spu_cmd_if.sink         cmd,
    spu_res_if.source       res
);
    localparam logic [spu_pkg::COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic signed [spu_pkg::OUT_XY_W-1:0] XY_MAX =
        signed'(spu_pkg::OUT_XY_W'((1 << (spu_pkg::OUT_XY_W - 1)) - 1));
    localparam logic signed [spu_pkg::OUT_XY_W-1:0] XY_MIN = -XY_MAX - 1;
    localparam logic [spu_pkg::F_W-1:0] XY_LIM = spu_pkg::F_W'(1 << (spu_pkg::OUT_XY_W - 1));
    localparam logic [spu_pkg::PROD_W-1:0] F_HALF =
        spu_pkg::PROD_W'(spu_pkg::ANG_QUARTER_TURN);

    spu_pkg::state_t state_reg, state_next;

    logic signed [spu_pkg::SUM_W-1:0] sum_reg [3];
    logic [spu_pkg::COUNT_BITS-1:0]   count_reg;
    logic signed [spu_pkg::IN_W-1:0]  centre_reg [3];
    logic                             centre_ready_reg;
    logic [spu_pkg::RAD_W-1:0]        lr_reg;
    logic [1:0]                       axis_reg;

    logic                             measure_reg;
    logic signed [spu_pkg::IN_W-1:0]  p_reg [3];
    logic signed [spu_pkg::DIFF_W-1:0] d_reg [3];
    logic [spu_pkg::PROD_W-1:0]       prod_reg;
    logic [spu_pkg::RHO2_W-1:0]       rho2_reg;
    logic [spu_pkg::ROOT_W-1:0]       rho_s_reg;
    logic [spu_pkg::ANG_W-1:0]        dq_reg;
    logic [spu_pkg::F_W-1:0]          f_reg;

    logic signed [spu_pkg::OUT_XY_W-1:0] new_x_reg;
    logic signed [spu_pkg::OUT_XY_W-1:0] new_y_reg;
    logic [spu_pkg::OUT_Z_W-1:0]         new_z_reg;
    logic                                fe_reg;
    logic                                status_reg;

    logic                          accept;
    spu_pkg::req_t                 req;
    logic [spu_pkg::MUL_W-1:0]     mul_a;
    logic [spu_pkg::MUL_W-1:0]     mul_b;
    logic [spu_pkg::MAG_W-1:0]     mag [3];
    logic [spu_pkg::SUM_W-1:0]     sum_abs;
    logic                          div_start;
    logic [spu_pkg::DIV_N_W-1:0]   div_num;
    logic [spu_pkg::DIV_D_W-1:0]   div_den;
    spu_pkg::unit_stat_t           div_stat;
    logic [spu_pkg::DIV_N_W-1:0]   div_quo;
    logic                          sqrt_start;
    logic [spu_pkg::SQRT_IN_W-1:0] sqrt_op;
    spu_pkg::unit_stat_t           sqrt_stat;
    logic [spu_pkg::ROOT_W-1:0]    sqrt_root;
    logic [spu_pkg::REM_W-1:0]     sqrt_rem;
    logic                          cord_start;
    spu_pkg::unit_stat_t           cord_stat;
    logic [spu_pkg::ANG_W-2:0]     cord_angle;
    logic [spu_pkg::RAD_W-1:0]     r_round;
    logic [spu_pkg::PROD_W-1:0]    f_sum;
    logic [spu_pkg::IN_W-1:0]      centre_q;

    function automatic logic signed [spu_pkg::OUT_XY_W-1:0] pack_xy(
        input logic neg, input logic [spu_pkg::F_W-1:0] m);
        logic signed [spu_pkg::OUT_XY_W-1:0] v;
        v = signed'(m[spu_pkg::OUT_XY_W-1:0]);
        if (neg)
        begin
            pack_xy = (m >= XY_LIM) ? XY_MIN : -v;
        end
        else
        begin
            pack_xy = (m >= XY_LIM) ? XY_MAX : v;
        end
    endfunction

    spu_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .stat  (div_stat),
        .quo   (div_quo)
    );

    spu_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .op    (sqrt_op),
        .stat  (sqrt_stat),
        .root  (sqrt_root),
        .rem   (sqrt_rem)
    );

    spu_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cord_start),
        .x0    (spu_pkg::ROOT_W'({mag[2], spu_pkg::RHO_EXTRA'(0)})),
        .y0    (rho_s_reg),
        .stat  (cord_stat),
        .angle (cord_angle)
    );

    assign accept = cmd.valid && cmd.ready;
    assign req    = spu_pkg::req_t'(cmd.req_type);

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = d_reg[i][spu_pkg::DIFF_W-1] ?
                     spu_pkg::MAG_W'(-d_reg[i]) : spu_pkg::MAG_W'(d_reg[i]);
        end
        sum_abs  = sum_reg[axis_reg][spu_pkg::SUM_W-1] ?
                   spu_pkg::SUM_W'(-sum_reg[axis_reg]) : spu_pkg::SUM_W'(sum_reg[axis_reg]);
        centre_q = div_quo[spu_pkg::IN_W-1:0];
        // Round to nearest: the remainder beyond the root exceeds it.
        r_round  = spu_pkg::RAD_W'(sqrt_root) +
                   spu_pkg::RAD_W'(sqrt_rem > spu_pkg::REM_W'(sqrt_root));
        f_sum    = prod_reg + F_HALF;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            spu_pkg::ST_IDLE:
            begin
                if (accept && (req == spu_pkg::REQ_MEASURE || req == spu_pkg::REQ_TRANSFORM))
                begin
                    if (count_reg == '0)
                    begin
                        state_next = spu_pkg::ST_OUT;
                    end
                    else if (!centre_ready_reg)
                    begin
                        state_next = spu_pkg::ST_CDIV;
                    end
                    else
                    begin
                        state_next = spu_pkg::ST_DIFF;
                    end
                end
            end
            spu_pkg::ST_CDIV:      state_next = spu_pkg::ST_CWAIT;
            spu_pkg::ST_CWAIT:
            begin
                if (div_stat.done)
                begin
                    state_next = (axis_reg == 2'd2) ? spu_pkg::ST_DIFF : spu_pkg::ST_CDIV;
                end
            end
            spu_pkg::ST_DIFF:      state_next = spu_pkg::ST_SQ_X;
            spu_pkg::ST_SQ_X:      state_next = spu_pkg::ST_SQ_Y;
            spu_pkg::ST_SQ_Y:      state_next = spu_pkg::ST_SQ_Z;
            spu_pkg::ST_SQ_Z:      state_next = spu_pkg::ST_SQ_SUM;
            spu_pkg::ST_SQ_SUM:    state_next = spu_pkg::ST_R_WAIT;
            spu_pkg::ST_R_WAIT:
            begin
                if (sqrt_stat.done)
                begin
                    if (measure_reg)
                    begin
                        state_next = spu_pkg::ST_OUT;
                    end
                    else if (rho2_reg == '0)
                    begin
                        state_next = spu_pkg::ST_F_MUL;
                    end
                    else
                    begin
                        state_next = spu_pkg::ST_RHO_START;
                    end
                end
            end
            spu_pkg::ST_RHO_START: state_next = spu_pkg::ST_RHO_WAIT;
            spu_pkg::ST_RHO_WAIT:
            begin
                if (sqrt_stat.done)
                begin
                    state_next = (d_reg[2] == '0) ? spu_pkg::ST_F_MUL : spu_pkg::ST_CORD_START;
                end
            end
            spu_pkg::ST_CORD_START: state_next = spu_pkg::ST_CORD_WAIT;
            spu_pkg::ST_CORD_WAIT:
            begin
                if (cord_stat.done)
                begin
                    state_next = spu_pkg::ST_F_MUL;
                end
            end
            spu_pkg::ST_F_MUL:     state_next = spu_pkg::ST_F_RND;
            spu_pkg::ST_F_RND:
            begin
                state_next = (rho2_reg == '0) ? spu_pkg::ST_OUT : spu_pkg::ST_MX_MUL;
            end
            spu_pkg::ST_MX_MUL:    state_next = spu_pkg::ST_MX_DIV;
            spu_pkg::ST_MX_DIV:    state_next = spu_pkg::ST_MX_WAIT;
            spu_pkg::ST_MX_WAIT:
            begin
                if (div_stat.done)
                begin
                    state_next = (axis_reg == 2'd1) ? spu_pkg::ST_OUT : spu_pkg::ST_MX_MUL;
                end
            end
            spu_pkg::ST_OUT:
            begin
                if (res.ready)
                begin
                    state_next = spu_pkg::ST_IDLE;
                end
            end
            default:               state_next = spu_pkg::ST_IDLE;
        endcase
    end

    // Unit controls and shared multiplier operands.
    always_comb
    begin
        div_start  = 1'b0;
        div_num    = '0;
        div_den    = '0;
        sqrt_start = 1'b0;
        sqrt_op    = '0;
        cord_start = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        unique case (state_reg)
            spu_pkg::ST_CDIV:
            begin
                div_start = 1'b1;
                div_num   = spu_pkg::DIV_N_W'(sum_abs) + spu_pkg::DIV_N_W'(count_reg >> 1);
                div_den   = spu_pkg::DIV_D_W'(count_reg);
            end
            spu_pkg::ST_SQ_X:
            begin
                mul_a = spu_pkg::MUL_W'(mag[0]);
                mul_b = spu_pkg::MUL_W'(mag[0]);
            end
            spu_pkg::ST_SQ_Y:
            begin
                mul_a = spu_pkg::MUL_W'(mag[1]);
                mul_b = spu_pkg::MUL_W'(mag[1]);
            end
            spu_pkg::ST_SQ_Z:
            begin
                mul_a = spu_pkg::MUL_W'(mag[2]);
                mul_b = spu_pkg::MUL_W'(mag[2]);
            end
            spu_pkg::ST_SQ_SUM:
            begin
                sqrt_start = 1'b1;
                sqrt_op    = spu_pkg::SQRT_IN_W'(spu_pkg::R2_W'(rho2_reg) +
                                                 spu_pkg::R2_W'(prod_reg));
            end
            spu_pkg::ST_RHO_START:
            begin
                sqrt_start = 1'b1;
                sqrt_op    = spu_pkg::SQRT_IN_W'({rho2_reg, (2 * spu_pkg::RHO_EXTRA)'(0)});
            end
            spu_pkg::ST_CORD_START:
            begin
                cord_start = 1'b1;
            end
            spu_pkg::ST_F_MUL:
            begin
                mul_a = spu_pkg::MUL_W'(lr_reg);
                mul_b = spu_pkg::MUL_W'(dq_reg);
            end
            spu_pkg::ST_MX_MUL:
            begin
                mul_a = spu_pkg::MUL_W'(f_reg);
                mul_b = spu_pkg::MUL_W'(mag[axis_reg]);
            end
            spu_pkg::ST_MX_DIV:
            begin
                div_start = 1'b1;
                div_num   = (spu_pkg::DIV_N_W'(prod_reg[spu_pkg::F_W+spu_pkg::MAG_W-1:0])
                             << spu_pkg::RHO_EXTRA) + spu_pkg::DIV_N_W'(rho_s_reg >> 1);
                div_den   = spu_pkg::DIV_D_W'(rho_s_reg);
            end
            default:
            begin
            end
        endcase
    end

    // Accumulated state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= spu_pkg::ST_IDLE;
            count_reg        <= '0;
            centre_ready_reg <= 1'b0;
            lr_reg           <= '0;
            axis_reg         <= '0;
            for (int i = 0; i < 3; i++)
            begin
                sum_reg[i]    <= '0;
                centre_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (accept && req == spu_pkg::REQ_CLEAR)
            begin
                count_reg        <= '0;
                centre_ready_reg <= 1'b0;
                lr_reg           <= '0;
                for (int i = 0; i < 3; i++)
                begin
                    sum_reg[i]    <= '0;
                    centre_reg[i] <= '0;
                end
            end
            else if (accept && req == spu_pkg::REQ_ACCUMULATE && count_reg != COUNT_MAX)
            begin
                count_reg  <= count_reg + 1'b1;
                sum_reg[0] <= sum_reg[0] + spu_pkg::SUM_W'(cmd.point_x);
                sum_reg[1] <= sum_reg[1] + spu_pkg::SUM_W'(cmd.point_y);
                sum_reg[2] <= sum_reg[2] + spu_pkg::SUM_W'(cmd.point_z);
            end
            if (accept)
            begin
                axis_reg <= '0;
            end
            if (state_reg == spu_pkg::ST_CWAIT && div_stat.done)
            begin
                centre_reg[axis_reg] <= sum_reg[axis_reg][spu_pkg::SUM_W-1] ?
                                        -signed'(centre_q) : signed'(centre_q);
                if (axis_reg == 2'd2)
                begin
                    centre_ready_reg <= 1'b1;
                    axis_reg         <= '0;
                end
                else
                begin
                    axis_reg <= axis_reg + 1'b1;
                end
            end
            if (state_reg == spu_pkg::ST_R_WAIT && sqrt_stat.done && measure_reg &&
                r_round > lr_reg)
            begin
                lr_reg <= r_round;
            end
            if (state_reg == spu_pkg::ST_MX_WAIT && div_stat.done)
            begin
                axis_reg <= axis_reg + 1'b1;
            end
        end
    end

    // Item datapath.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            measure_reg <= req == spu_pkg::REQ_MEASURE;
            p_reg[0]    <= cmd.point_x;
            p_reg[1]    <= cmd.point_y;
            p_reg[2]    <= cmd.point_z;
            fe_reg      <= cmd.fiber_end;
            new_x_reg   <= '0;
            new_y_reg   <= '0;
            new_z_reg   <= '0;
            status_reg  <= count_reg == '0;
        end
        if (mul_a != '0 || mul_b != '0 || state_reg == spu_pkg::ST_SQ_X ||
            state_reg == spu_pkg::ST_SQ_Y || state_reg == spu_pkg::ST_SQ_Z ||
            state_reg == spu_pkg::ST_F_MUL || state_reg == spu_pkg::ST_MX_MUL)
        begin
            prod_reg <= spu_pkg::PROD_W'(mul_a * mul_b);
        end
        unique case (state_reg)
            spu_pkg::ST_DIFF:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    d_reg[i] <= spu_pkg::DIFF_W'(p_reg[i]) - spu_pkg::DIFF_W'(centre_reg[i]);
                end
            end
            spu_pkg::ST_SQ_Y:
            begin
                rho2_reg <= spu_pkg::RHO2_W'(prod_reg);
            end
            spu_pkg::ST_SQ_Z:
            begin
                rho2_reg <= rho2_reg + spu_pkg::RHO2_W'(prod_reg);
            end
            spu_pkg::ST_R_WAIT:
            begin
                if (sqrt_stat.done)
                begin
                    new_z_reg <= (r_round > spu_pkg::RAD_W'({spu_pkg::OUT_Z_W{1'b1}})) ?
                                 '1 : spu_pkg::OUT_Z_W'(r_round);
                    // A point on the z axis has no azimuth and a polar angle of 0 or pi.
                    dq_reg    <= d_reg[2][spu_pkg::DIFF_W-1] ? spu_pkg::ANG_HALF_TURN : '0;
                end
            end
            spu_pkg::ST_RHO_WAIT:
            begin
                if (sqrt_stat.done)
                begin
                    rho_s_reg <= sqrt_root;
                    dq_reg    <= spu_pkg::ANG_QUARTER_TURN;
                end
            end
            spu_pkg::ST_CORD_WAIT:
            begin
                if (cord_stat.done)
                begin
                    dq_reg <= d_reg[2][spu_pkg::DIFF_W-1] ?
                              spu_pkg::ANG_HALF_TURN - spu_pkg::ANG_W'(cord_angle) :
                              spu_pkg::ANG_W'(cord_angle);
                end
            end
            spu_pkg::ST_F_RND:
            begin
                f_reg <= f_sum[spu_pkg::ANG_W-1 +: spu_pkg::F_W];
                if (rho2_reg == '0)
                begin
                    new_x_reg <= pack_xy(1'b0, f_sum[spu_pkg::ANG_W-1 +: spu_pkg::F_W]);
                end
            end
            spu_pkg::ST_MX_WAIT:
            begin
                if (div_stat.done)
                begin
                    if (axis_reg == 2'd0)
                    begin
                        new_x_reg <= pack_xy(d_reg[0][spu_pkg::DIFF_W-1],
                                             div_quo[spu_pkg::F_W-1:0]);
                    end
                    else
                    begin
                        new_y_reg <= pack_xy(d_reg[1][spu_pkg::DIFF_W-1],
                                             div_quo[spu_pkg::F_W-1:0]);
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    assign cmd.ready         = state_reg == spu_pkg::ST_IDLE;
    assign res.valid         = state_reg == spu_pkg::ST_OUT;
    assign res.new_x         = new_x_reg;
    assign res.new_y         = new_y_reg;
    assign res.new_z         = new_z_reg;
    assign res.fiber_end_out = fe_reg;
    assign res.status        = status_reg;

    a_no_accept_while_holding: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> !cmd.ready)
        else $error("input accepted while a result is pending");

    a_centre_needs_points: assert property (@(posedge clk) disable iff (!rst_n)
        centre_ready_reg |-> (count_reg != '0))
        else $error("centre fixed with no accumulated points");

    a_div_start_free: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    a_sqrt_start_free: assert property (@(posedge clk) disable iff (!rst_n)
        sqrt_start |-> !sqrt_stat.busy)
        else $error("square root started while busy");

    a_empty_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.status) |->
        (res.new_x == '0 && res.new_y == '0 && res.new_z == '0))
        else $error("status result carries nonzero coordinates");
endmodule
`default_nettype wire

// ----- rtl/core/spu_div.sv -----
`default_nettype none
module spu_div (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [spu_pkg::DIV_N_W-1:0]   num,
    input  wire logic [spu_pkg::DIV_D_W-1:0]   den,
    output spu_pkg::unit_stat_t                stat,
    output logic [spu_pkg::DIV_N_W-1:0]        quo
);
    logic [spu_pkg::DIV_N_W-1:0]   num_reg;
    logic [spu_pkg::DIV_D_W-1:0]   den_reg;
    logic [spu_pkg::DIV_D_W-1:0]   rem_reg;
    logic [spu_pkg::DIV_N_W-1:0]   quo_reg;
    logic [spu_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                          busy_reg;
    logic                          done_reg;

    logic [spu_pkg::DIV_D_W:0] rem_sh;
    logic [spu_pkg::DIV_D_W:0] rem_sub;
    logic                      fits;

    // One restoring step: bring down the next numerator bit, subtract if it fits.
    always_comb
    begin
        rem_sh  = {rem_reg, num_reg[spu_pkg::DIV_N_W-1]};
        fits    = rem_sh >= {1'b0, den_reg};
        rem_sub = rem_sh - {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == spu_pkg::DIV_CNT_W'(spu_pkg::DIV_N_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= num_reg << 1;
            rem_reg <= fits ? rem_sub[spu_pkg::DIV_D_W-1:0] : rem_sh[spu_pkg::DIV_D_W-1:0];
            quo_reg <= {quo_reg[spu_pkg::DIV_N_W-2:0], fits};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quo       = quo_reg;
endmodule
`default_nettype wire

// ----- rtl/core/spu_sqrt.sv -----
`default_nettype none
module spu_sqrt (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic [spu_pkg::SQRT_IN_W-1:0]   op,
    output spu_pkg::unit_stat_t                  stat,
    output logic [spu_pkg::ROOT_W-1:0]           root,
    output logic [spu_pkg::REM_W-1:0]            rem
);
    logic [spu_pkg::SQRT_IN_W-1:0]  op_reg;
    logic [spu_pkg::ROOT_W-1:0]     root_reg;
    logic [spu_pkg::REM_W-1:0]      rem_reg;
    logic [spu_pkg::SQRT_CNT_W-1:0] cnt_reg;
    logic                           busy_reg;
    logic                           done_reg;

    logic [spu_pkg::REM_W-1:0] rem_sh;
    logic [spu_pkg::REM_W-1:0] trial;
    logic                      fits;

    // Digit-by-digit square root, two operand bits per step.
    always_comb
    begin
        rem_sh = {rem_reg[spu_pkg::REM_W-3:0], op_reg[spu_pkg::SQRT_IN_W-1 -: 2]};
        trial  = {root_reg, 2'b01};
        fits   = rem_sh >= trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == spu_pkg::SQRT_CNT_W'(spu_pkg::ROOT_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            op_reg   <= op;
            root_reg <= '0;
            rem_reg  <= '0;
        end
        else if (busy_reg)
        begin
            op_reg   <= op_reg << 2;
            rem_reg  <= fits ? rem_sh - trial : rem_sh;
            root_reg <= {root_reg[spu_pkg::ROOT_W-2:0], fits};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign root      = root_reg;
    assign rem       = rem_reg;
endmodule
`default_nettype wire

// ----- rtl/core/spu_cordic.sv -----
`default_nettype none
module spu_cordic (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [spu_pkg::ROOT_W-1:0]   x0,
    input  wire logic [spu_pkg::ROOT_W-1:0]   y0,
    output spu_pkg::unit_stat_t               stat,
    output logic [spu_pkg::ANG_W-2:0]         angle
);
    logic signed [spu_pkg::X_W-1:0] x_reg;
    logic signed [spu_pkg::X_W-1:0] y_reg;
    logic signed [spu_pkg::Z_W-1:0] z_reg;
    logic [spu_pkg::CSTEP_W-1:0]    step_reg;
    logic                           busy_reg;
    logic                           done_reg;

    logic signed [spu_pkg::X_W-1:0] xs;
    logic signed [spu_pkg::X_W-1:0] ys;
    logic signed [spu_pkg::Z_W-1:0] at;

    always_comb
    begin
        xs = x_reg >>> step_reg;
        ys = y_reg >>> step_reg;
        at = signed'(spu_pkg::Z_W'(spu_pkg::ATAN_TAB[spu_pkg::TAB_IDX_W'(step_reg)]));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == spu_pkg::CSTEP_W'(spu_pkg::CORDIC_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Vectoring: drive y toward zero and collect the rotated angle in z.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg <= signed'(spu_pkg::X_W'(x0));
            y_reg <= signed'(spu_pkg::X_W'(y0));
            z_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (y_reg > 0)
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + at;
            end
            else
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - at;
            end
        end
    end

    always_comb
    begin
        if (z_reg < 0)
        begin
            angle = '0;
        end
        else if (z_reg > signed'(spu_pkg::Z_W'(spu_pkg::ANG_QUARTER_TURN)))
        begin
            angle = spu_pkg::ANG_QUARTER_TURN[spu_pkg::ANG_W-2:0];
        end
        else
        begin
            angle = z_reg[spu_pkg::ANG_W-2:0];
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
endmodule
`default_nettype wire
